[rtl/core/ptld_pkg.sv]
// Shared constants, codes and control types of the priority task list dispatcher.
`timescale 1ns / 1ps

package ptld_pkg;

    // Default pool size.
    localparam int MAX_TASKS_DEF = 64;

    // Field widths fixed by the request and response formats.
    localparam int OP_W   = 3;
    localparam int HDL_W  = 6;
    localparam int PRI_W  = 16;
    localparam int HND_W  = 16;
    localparam int CTX_W  = 32;
    localparam int STAT_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 3'd2;
    localparam logic [OP_W-1:0] OP_START  = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;

    // Response status codes.
    localparam logic [STAT_W-1:0] RS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] RS_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] RS_BAD      = 2'd2;
    localparam logic [STAT_W-1:0] RS_FINISHED = 2'd3;

    // Datapath micro-steps issued by the controller.
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_ADD0,
        STEP_ADD1,
        STEP_WALK,
        STEP_INS0,
        STEP_INS1,
        STEP_DEL0,
        STEP_DEL1,
        STEP_CHG0,
        STEP_CHG1,
        STEP_NX0,
        STEP_NX1,
        STEP_SIMPLE
    } ptld_step_t;

    // Command from controller to datapath.
    typedef struct packed {
        ptld_step_t step;
        logic       load_req;
        logic       push_out;
    } ptld_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic full;
        logic bad;
        logic hit;
        logic cur_end;
        logic dispatch;
        logic out_free;
    } ptld_stat_t;

endpackage

[rtl/core/ptld_if.sv]
// Request and response channel interfaces of the priority task list dispatcher.
`timescale 1ns / 1ps

interface ptld_req_if
    import ptld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [HDL_W-1:0]  handle;
    logic [PRI_W-1:0]  priority_req;
    logic [HND_W-1:0]  handler_code;
    logic [CTX_W-1:0]  context_tag;

    modport source (output valid, operation, handle, priority_req, handler_code,
                    context_tag, input ready);
    modport sink   (input valid, operation, handle, priority_req, handler_code,
                    context_tag, output ready);
endinterface

interface ptld_rsp_if
    import ptld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [HDL_W-1:0]  task_handle;
    logic [HND_W-1:0]  task_handler;
    logic [CTX_W-1:0]  task_context;
    logic [PRI_W-1:0]  task_priority;

    modport source (output valid, status, task_handle, task_handler, task_context,
                    task_priority, input ready);
    modport sink   (input valid, status, task_handle, task_handler, task_context,
                    task_priority, output ready);
endinterface

[rtl/core/ptld_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps

module ptld_ctrl
    import ptld_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] in_op,
    output logic            in_ready,
    output ptld_cmd_t       cmd,
    input  ptld_stat_t      st
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_ADD0   = 14'b00000000000010,
        S_ADD1   = 14'b00000000000100,
        S_WALK   = 14'b00000000001000,
        S_INS0   = 14'b00000000010000,
        S_INS1   = 14'b00000000100000,
        S_DEL0   = 14'b00000001000000,
        S_DEL1   = 14'b00000010000000,
        S_CHG0   = 14'b00000100000000,
        S_CHG1   = 14'b00001000000000,
        S_NX0    = 14'b00010000000000,
        S_NX1    = 14'b00100000000000,
        S_SIMPLE = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        cmd.step     = STEP_NONE;
        cmd.load_req = 1'b0;
        cmd.push_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_req = in_valid;
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_ADD:    state_next = S_ADD0;
                        OP_DELETE: state_next = S_DEL0;
                        OP_CHANGE: state_next = S_CHG0;
                        OP_NEXT:   state_next = S_NX0;
                        default:   state_next = S_SIMPLE;
                    endcase
                end
            end
            S_ADD0:
            begin
                cmd.step   = STEP_ADD0;
                state_next = st.full ? S_OUT : S_ADD1;
            end
            S_ADD1:
            begin
                cmd.step   = STEP_ADD1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.step   = STEP_WALK;
                state_next = st.hit ? S_INS0 : S_WALK;
            end
            S_INS0:
            begin
                cmd.step   = STEP_INS0;
                state_next = S_INS1;
            end
            S_INS1:
            begin
                cmd.step   = STEP_INS1;
                state_next = S_OUT;
            end
            S_DEL0:
            begin
                cmd.step   = STEP_DEL0;
                state_next = st.bad ? S_OUT : S_DEL1;
            end
            S_DEL1:
            begin
                cmd.step   = STEP_DEL1;
                state_next = S_OUT;
            end
            S_CHG0:
            begin
                cmd.step   = STEP_CHG0;
                state_next = st.bad ? S_OUT : S_CHG1;
            end
            S_CHG1:
            begin
                cmd.step   = STEP_CHG1;
                state_next = S_OUT;
            end
            S_NX0:
            begin
                cmd.step   = STEP_NX0;
                state_next = st.cur_end ? S_OUT : S_NX1;
            end
            S_NX1:
            begin
                cmd.step   = STEP_NX1;
                state_next = st.dispatch ? S_OUT : S_NX0;
            end
            S_SIMPLE:
            begin
                cmd.step   = STEP_SIMPLE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.push_out = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/ptld_dp.sv]
// Datapath: slot memories, free stack, list pointers and the response register.
`timescale 1ns / 1ps

module ptld_dp
    import ptld_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ptld_cmd_t          cmd,
    output ptld_stat_t         st,
    input  logic [OP_W-1:0]    in_operation,
    input  logic [HDL_W-1:0]   in_handle,
    input  logic [PRI_W-1:0]   in_priority,
    input  logic [HND_W-1:0]   in_handler,
    input  logic [CTX_W-1:0]   in_context,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  out_status,
    output logic [HDL_W-1:0]   out_handle,
    output logic [HND_W-1:0]   out_handler,
    output logic [CTX_W-1:0]   out_context,
    output logic [PRI_W-1:0]   out_priority
);

    // Slot index width and link width; the link value MAX_TASKS is the sentinel.
    localparam int SW = $clog2(MAX_TASKS);
    localparam int IW = $clog2(MAX_TASKS + 1);
    localparam logic [IW-1:0] SENT = IW'(MAX_TASKS);

    // Slot memories with registered read data.
    logic [IW-1:0]    nxt_mem [MAX_TASKS];
    logic [IW-1:0]    prv_mem [MAX_TASKS];
    logic [PRI_W-1:0] pri_mem [MAX_TASKS];
    logic [HND_W-1:0] hnd_mem [MAX_TASKS];
    logic [CTX_W-1:0] ctx_mem [MAX_TASKS];
    logic [SW-1:0]    fs_mem  [MAX_TASKS];

    logic [IW-1:0]    nxt_q, prv_q;
    logic [PRI_W-1:0] pri_q;
    logic [HND_W-1:0] hnd_q;
    logic [CTX_W-1:0] ctx_q;
    logic [SW-1:0]    fs_q;

    logic [SW-1:0]    ra;
    logic [SW-1:0]    fs_ra;
    logic             nxt_we, prv_we, hnd_we, fill_we, fs_we;
    logic [SW-1:0]    nxt_wa, prv_wa, hnd_wa, fill_wa, fs_wa;
    logic [IW-1:0]    nxt_wd, prv_wd;
    logic [HND_W-1:0] hnd_wd;
    logic [SW-1:0]    fs_wd;

    // Control registers.
    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic [IW-1:0]        cursor_reg, cursor_next;
    logic [IW-1:0]        run_slot_reg, run_slot_next;
    logic                 run_valid_reg, run_valid_next;
    logic [IW-1:0]        free_top_reg, free_top_next;
    logic [IW-1:0]        hw_reg, hw_next;
    logic [MAX_TASKS-1:0] in_use_reg, in_use_next;
    logic [MAX_TASKS-1:0] deferred_reg, deferred_next;
    logic                 out_valid_reg, out_valid_next;

    // Request, walk and result registers.
    logic [OP_W-1:0]   op_reg;
    logic [HDL_W-1:0]  handle_reg;
    logic [PRI_W-1:0]  req_pri_reg;
    logic [HND_W-1:0]  req_hnd_reg;
    logic [CTX_W-1:0]  req_ctx_reg;
    logic [SW-1:0]     s_reg, s_next;
    logic [IW-1:0]     f_reg, f_next;
    logic [IW-1:0]     p_reg, p_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [SW-1:0]     res_slot_reg, res_slot_next;
    logic [HND_W-1:0]  res_hnd_reg, res_hnd_next;
    logic [CTX_W-1:0]  res_ctx_reg, res_ctx_next;
    logic [PRI_W-1:0]  res_pri_reg, res_pri_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [SW-1:0]     out_slot_reg;
    logic [HND_W-1:0]  out_hnd_reg;
    logic [CTX_W-1:0]  out_ctx_reg;
    logic [PRI_W-1:0]  out_pri_reg;

    logic [SW-1:0] h_idx, cur_idx, s_val;
    logic          h_ok, defer_new;

    assign h_idx   = SW'(handle_reg);
    assign cur_idx = SW'(cursor_reg);
    assign h_ok    = (32'(handle_reg) < MAX_TASKS) && in_use_reg[h_idx];
    assign s_val   = (free_top_reg >= hw_reg) ? SW'(free_top_reg) : fs_q;
    assign defer_new = run_valid_reg && (hnd_q != '0) && (pri_q <= req_pri_reg);

    // Status to the controller.
    assign st.full     = (free_top_reg == SENT);
    assign st.bad      = !h_ok;
    assign st.hit      = (f_reg == SENT) || (pri_q > req_pri_reg);
    assign st.cur_end  = (cursor_reg == SENT);
    assign st.dispatch = !deferred_reg[cur_idx] && (hnd_q != '0);
    assign st.out_free = !out_valid_reg || out_ready;

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
        if (fill_we)
        begin
            pri_mem[fill_wa] <= req_pri_reg;
            ctx_mem[fill_wa] <= req_ctx_reg;
        end
        if (hnd_we)
        begin
            hnd_mem[hnd_wa] <= hnd_wd;
        end
        if (fs_we)
        begin
            fs_mem[fs_wa] <= fs_wd;
        end
        nxt_q <= nxt_mem[ra];
        prv_q <= prv_mem[ra];
        pri_q <= pri_mem[ra];
        hnd_q <= hnd_mem[ra];
        ctx_q <= ctx_mem[ra];
        fs_q  <= fs_mem[fs_ra];
    end

    // Per-step datapath operations.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        cursor_next     = cursor_reg;
        run_slot_next   = run_slot_reg;
        run_valid_next  = run_valid_reg;
        free_top_next   = free_top_reg;
        hw_next         = hw_reg;
        in_use_next     = in_use_reg;
        deferred_next   = deferred_reg;
        s_next          = s_reg;
        f_next          = f_reg;
        p_next          = p_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_hnd_next    = res_hnd_reg;
        res_ctx_next    = res_ctx_reg;
        res_pri_next    = res_pri_reg;
        ra      = '0;
        fs_ra   = SW'(free_top_reg);
        nxt_we  = 1'b0;
        nxt_wa  = '0;
        nxt_wd  = '0;
        prv_we  = 1'b0;
        prv_wa  = '0;
        prv_wd  = '0;
        fill_we = 1'b0;
        fill_wa = '0;
        hnd_we  = 1'b0;
        hnd_wa  = '0;
        hnd_wd  = '0;
        fs_we   = 1'b0;
        fs_wa   = '0;
        fs_wd   = '0;

        case (cmd.step)
            STEP_ADD0:
            begin
                // Fetch the free slot and the running task's handler and priority.
                ra = SW'(run_slot_reg);
                if (free_top_reg == SENT)
                begin
                    res_status_next = RS_FULL;
                    res_slot_next   = '0;
                    res_hnd_next    = '0;
                    res_ctx_next    = '0;
                    res_pri_next    = '0;
                end
            end
            STEP_ADD1:
            begin
                // Claim the slot, store the task and start the walk at the head.
                s_next        = s_val;
                fill_we       = 1'b1;
                fill_wa       = s_val;
                hnd_we        = 1'b1;
                hnd_wa        = s_val;
                hnd_wd        = req_hnd_reg;
                free_top_next = free_top_reg + 1'b1;
                in_use_next[s_val]   = 1'b1;
                deferred_next[s_val] = defer_new;
                f_next = head_reg;
                ra     = SW'(head_reg);
            end
            STEP_WALK:
            begin
                // Stop at the first entry of higher priority value, else advance.
                if ((f_reg == SENT) || (pri_q > req_pri_reg))
                begin
                    p_next = (f_reg == SENT) ? tail_reg : prv_q;
                end
                else
                begin
                    f_next = nxt_q;
                    ra     = SW'(nxt_q);
                end
            end
            STEP_INS0:
            begin
                // Link the new slot to its neighbors.
                nxt_we = 1'b1;
                nxt_wa = s_reg;
                nxt_wd = f_reg;
                prv_we = 1'b1;
                prv_wa = s_reg;
                prv_wd = p_reg;
                if (cursor_reg == f_reg)
                begin
                    cursor_next = IW'(s_reg);
                end
            end
            STEP_INS1:
            begin
                // Point the neighbors at the new slot.
                if (p_reg == SENT)
                begin
                    head_next = IW'(s_reg);
                end
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wa = SW'(p_reg);
                    nxt_wd = IW'(s_reg);
                end
                if (f_reg == SENT)
                begin
                    tail_next = IW'(s_reg);
                end
                else
                begin
                    prv_we = 1'b1;
                    prv_wa = SW'(f_reg);
                    prv_wd = IW'(s_reg);
                end
                res_status_next = RS_OK;
                res_slot_next   = s_reg;
                res_hnd_next    = req_hnd_reg;
                res_ctx_next    = req_ctx_reg;
                res_pri_next    = req_pri_reg;
            end
            STEP_DEL0, STEP_CHG0:
            begin
                // Check the handle and fetch the slot; a change also writes the new handler.
                ra = h_idx;
                if (!h_ok)
                begin
                    res_status_next = RS_BAD;
                    res_slot_next   = '0;
                    res_hnd_next    = '0;
                    res_ctx_next    = '0;
                    res_pri_next    = '0;
                end
                else if (cmd.step == STEP_CHG0)
                begin
                    hnd_we = 1'b1;
                    hnd_wa = h_idx;
                    hnd_wd = req_hnd_reg;
                end
            end
            STEP_DEL1:
            begin
                // Unlink the slot and push it back on the free stack.
                if (cursor_reg == IW'(h_idx))
                begin
                    cursor_next = nxt_q;
                end
                if (prv_q == SENT)
                begin
                    head_next = nxt_q;
                end
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wa = SW'(prv_q);
                    nxt_wd = nxt_q;
                end
                if (nxt_q == SENT)
                begin
                    tail_next = prv_q;
                end
                else
                begin
                    prv_we = 1'b1;
                    prv_wa = SW'(nxt_q);
                    prv_wd = prv_q;
                end
                if (run_slot_reg == IW'(h_idx))
                begin
                    run_valid_next = 1'b0;
                end
                in_use_next[h_idx]   = 1'b0;
                deferred_next[h_idx] = 1'b0;
                free_top_next = free_top_reg - 1'b1;
                fs_we = 1'b1;
                fs_wa = SW'(free_top_reg - 1'b1);
                fs_wd = h_idx;
                if (hw_reg < free_top_reg)
                begin
                    hw_next = free_top_reg;
                end
                res_status_next = RS_OK;
                res_slot_next   = h_idx;
                res_hnd_next    = hnd_q;
                res_ctx_next    = ctx_q;
                res_pri_next    = pri_q;
            end
            STEP_CHG1:
            begin
                res_status_next = RS_OK;
                res_slot_next   = h_idx;
                res_hnd_next    = req_hnd_reg;
                res_ctx_next    = ctx_q;
                res_pri_next    = pri_q;
            end
            STEP_NX0:
            begin
                // Fetch the cursor entry, or finish the pass at the sentinel.
                ra = cur_idx;
                if (cursor_reg == SENT)
                begin
                    run_slot_next   = SENT;
                    run_valid_next  = 1'b0;
                    res_status_next = RS_FINISHED;
                    res_slot_next   = '0;
                    res_hnd_next    = '0;
                    res_ctx_next    = '0;
                    res_pri_next    = '0;
                end
            end
            STEP_NX1:
            begin
                // Advance; a deferred entry is re-armed and skipped.
                cursor_next = nxt_q;
                if (deferred_reg[cur_idx])
                begin
                    deferred_next[cur_idx] = 1'b0;
                end
                else if (hnd_q != '0)
                begin
                    run_slot_next   = cursor_reg;
                    run_valid_next  = 1'b1;
                    res_status_next = RS_OK;
                    res_slot_next   = cur_idx;
                    res_hnd_next    = hnd_q;
                    res_ctx_next    = ctx_q;
                    res_pri_next    = pri_q;
                end
            end
            STEP_SIMPLE:
            begin
                // Start pass, or an unknown operation that changes nothing.
                if (op_reg == OP_START)
                begin
                    cursor_next    = head_reg;
                    run_slot_next  = SENT;
                    run_valid_next = 1'b0;
                end
                res_status_next = RS_OK;
                res_slot_next   = '0;
                res_hnd_next    = '0;
                res_ctx_next    = '0;
                res_pri_next    = '0;
            end
            default:
            begin
            end
        endcase

        // Response register handshake.
        out_valid_next = out_valid_reg;
        if (cmd.push_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= SENT;
            tail_reg      <= SENT;
            cursor_reg    <= SENT;
            run_slot_reg  <= SENT;
            run_valid_reg <= 1'b0;
            free_top_reg  <= '0;
            hw_reg        <= '0;
            in_use_reg    <= '0;
            deferred_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cursor_reg    <= cursor_next;
            run_slot_reg  <= run_slot_next;
            run_valid_reg <= run_valid_next;
            free_top_reg  <= free_top_next;
            hw_reg        <= hw_next;
            in_use_reg    <= in_use_next;
            deferred_reg  <= deferred_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg      <= in_operation;
            handle_reg  <= in_handle;
            req_pri_reg <= in_priority;
            req_hnd_reg <= in_handler;
            req_ctx_reg <= in_context;
        end
        s_reg          <= s_next;
        f_reg          <= f_next;
        p_reg          <= p_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_hnd_reg    <= res_hnd_next;
        res_ctx_reg    <= res_ctx_next;
        res_pri_reg    <= res_pri_next;
        if (cmd.push_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_hnd_reg    <= res_hnd_reg;
            out_ctx_reg    <= res_ctx_reg;
            out_pri_reg    <= res_pri_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_handle   = HDL_W'(out_slot_reg);
    assign out_handler  = out_hnd_reg;
    assign out_context  = out_ctx_reg;
    assign out_priority = out_pri_reg;

endmodule

[rtl/core/priority_task_list_dispatcher.sv]
// Top level: one request at a time; an add walks the list, next walks to the next task.
// Steps: start pass and unknown codes run a simple step; full pool or bad handle end at the
// first check; delete and change check, then unlink or report; an add fetches, claims a slot,
// walks to its place and links it in; next fetches and advances until a dispatch or pass end.
// Rate is set by the single read port of the slot memories; a stalled output adds its wait.
// Reset is asynchronous: the list is empty, all slots free, no pass and no current task.
`timescale 1ns / 1ps

module priority_task_list_dispatcher
    import ptld_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    ptld_req_if.sink    req,
    ptld_rsp_if.source  rsp
);

    ptld_cmd_t  cmd;
    ptld_stat_t st;

    // Sequencer.
    ptld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.operation),
        .in_ready (req.ready),
        .cmd      (cmd),
        .st       (st)
    );

    // Storage and list logic.
    ptld_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_operation (req.operation),
        .in_handle    (req.handle),
        .in_priority  (req.priority_req),
        .in_handler   (req.handler_code),
        .in_context   (req.context_tag),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_status   (rsp.status),
        .out_handle   (rsp.task_handle),
        .out_handler  (rsp.task_handler),
        .out_context  (rsp.task_context),
        .out_priority (rsp.task_priority)
    );

    // One request in flight: a taken request closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    // A response is only pushed into a free output register.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_out |-> st.out_free)
        else $error("response pushed over a pending one");

    // A taken response without a new push empties the output register.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !cmd.push_out) |=> !rsp.valid)
        else $error("response repeated");

endmodule

[sim/priority_task_list_dispatcher_tb.sv]
// Self-checking testbench of the priority task list dispatcher: directed, fill and random tests.
`timescale 1ns / 1ps

module priority_task_list_dispatcher_tb;
    import ptld_pkg::*;

    localparam int NTASK = MAX_TASKS_DEF;
    localparam int SENT = NTASK;
    localparam int CYCLE_LIMIT = 1500000;

    // One response as compared on the output channel.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HDL_W-1:0]  hdl;
        logic [HND_W-1:0]  hnd;
        logic [CTX_W-1:0]  ctx;
        logic [PRI_W-1:0]  pri;
    } task_rsp_t;

    // One request of the directed table; chk set when the response is typed in.
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [HDL_W-1:0] hdl;
        logic [PRI_W-1:0] pri;
        logic [HND_W-1:0] hnd;
        logic [CTX_W-1:0] ctx;
        bit               chk;
        task_rsp_t        rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    ptld_req_if req ();
    ptld_rsp_if rsp ();

    priority_task_list_dispatcher dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow copy of the task pool.
    int unsigned  lnk_next [NTASK+1];
    int unsigned  lnk_prev [NTASK+1];
    bit [15:0]    sh_pri [NTASK];
    bit [15:0]    sh_hnd [NTASK];
    bit [31:0]    sh_ctx [NTASK];
    bit           sh_def [NTASK];
    bit           sh_used [NTASK];
    int unsigned  free_stk [NTASK];
    int unsigned  free_cnt;
    int unsigned  cursor;
    int unsigned  cur_slot;
    bit           cur_valid;

    task_rsp_t    pending_rsp[$];
    int           fail_cnt;
    int unsigned  cycle_cnt = 0;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_off;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic task_rsp_t slot_rsp(int unsigned s);
        task_rsp_t r;
        r.status = RS_OK;
        r.hdl = s[5:0];
        r.hnd = sh_hnd[s];
        r.ctx = sh_ctx[s];
        r.pri = sh_pri[s];
        return r;
    endfunction

    function automatic task_rsp_t bare_rsp(logic [STAT_W-1:0] st);
        task_rsp_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i <= NTASK; i++)
        begin
            lnk_next[i] = SENT;
            lnk_prev[i] = SENT;
        end
        for (int i = 0; i < NTASK; i++)
        begin
            sh_pri[i] = 0;
            sh_hnd[i] = 0;
            sh_ctx[i] = 0;
            sh_def[i] = 0;
            sh_used[i] = 0;
            free_stk[i] = i;
        end
        free_cnt = 0;
        cursor = SENT;
        cur_slot = SENT;
        cur_valid = 0;
    endfunction

    // Predicts the response to one request and updates the shadow pool.
    function automatic task_rsp_t pool_apply(logic [OP_W-1:0] op, logic [HDL_W-1:0] h,
                                             logic [15:0] pri, logic [15:0] hnd,
                                             logic [31:0] ctx);
        int unsigned s;
        int unsigned f;
        int unsigned p;
        int unsigned n;
        bit ext;
        task_rsp_t r;
        case (op)
            OP_ADD:
            begin
                if (free_cnt >= NTASK)
                    return bare_rsp(RS_FULL);
                s = free_stk[free_cnt];
                free_cnt++;
                sh_pri[s] = pri;
                sh_hnd[s] = hnd;
                sh_ctx[s] = ctx;
                sh_used[s] = 1;
                ext = !(cur_valid && cur_slot < NTASK && sh_hnd[cur_slot] != 0);
                sh_def[s] = !ext && sh_pri[cur_slot] <= pri;
                // Ordered insert ahead of the first strictly larger priority.
                f = lnk_next[SENT];
                while (f != SENT)
                begin
                    if (sh_pri[f] > pri)
                    begin
                        p = lnk_prev[f];
                        lnk_prev[s] = p;
                        lnk_next[s] = f;
                        lnk_next[p] = s;
                        lnk_prev[f] = s;
                        if (cursor == f)
                            cursor = s;
                        return slot_rsp(s);
                    end
                    f = lnk_next[f];
                end
                if (cursor == SENT)
                    cursor = s;
                lnk_prev[s] = lnk_prev[SENT];
                lnk_next[s] = SENT;
                lnk_next[lnk_prev[SENT]] = s;
                lnk_prev[SENT] = s;
                return slot_rsp(s);
            end
            OP_DELETE:
            begin
                if (!sh_used[h] || free_cnt == 0)
                    return bare_rsp(RS_BAD);
                r = slot_rsp(h);
                p = lnk_prev[h];
                n = lnk_next[h];
                if (cursor == h)
                    cursor = n;
                lnk_next[p] = n;
                lnk_prev[n] = p;
                if (cur_slot == h)
                    cur_valid = 0;
                lnk_next[h] = SENT;
                lnk_prev[h] = SENT;
                sh_pri[h] = 0;
                sh_hnd[h] = 0;
                sh_ctx[h] = 0;
                sh_def[h] = 0;
                sh_used[h] = 0;
                free_cnt--;
                free_stk[free_cnt] = h;
                return r;
            end
            OP_CHANGE:
            begin
                if (!sh_used[h])
                    return bare_rsp(RS_BAD);
                sh_hnd[h] = hnd;
                return slot_rsp(h);
            end
            OP_START:
            begin
                cursor = lnk_next[SENT];
                cur_slot = SENT;
                cur_valid = 0;
                return bare_rsp(RS_OK);
            end
            OP_NEXT:
            begin
                // Deferred tasks are skipped once and re-armed.
                while (cursor != SENT)
                begin
                    s = cursor;
                    cursor = lnk_next[s];
                    if (sh_def[s])
                        sh_def[s] = 0;
                    else if (sh_hnd[s] != 0)
                    begin
                        cur_slot = s;
                        cur_valid = 1;
                        return slot_rsp(s);
                    end
                end
                cur_slot = SENT;
                cur_valid = 0;
                return bare_rsp(RS_FINISHED);
            end
            default:
                return bare_rsp(RS_OK);
        endcase
    endfunction

    // Sends one request and records its predicted response.
    task automatic send_request(logic [OP_W-1:0] op, logic [HDL_W-1:0] h,
                                logic [15:0] pri, logic [15:0] hnd, logic [31:0] ctx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.handle <= h;
        req.priority_req <= pri;
        req.handler_code <= hnd;
        req.context_tag <= ctx;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_rsp.push_back(pool_apply(op, h, pri, hnd, ctx));
        @(negedge clk);
    endtask

    task automatic drain_responses();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Response checker.
    always @(posedge clk)
    begin
        task_rsp_t got;
        task_rsp_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.status, rsp.task_handle, rsp.task_handler, rsp.task_context,
                   rsp.task_priority};
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response %h", got);
                fail_cnt++;
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (got.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, got.status);
                    fail_cnt++;
                end
                if (got.hdl !== exp_r.hdl)
                begin
                    $error("task_handle expected %0d actual %0d", exp_r.hdl, got.hdl);
                    fail_cnt++;
                end
                if (got.hnd !== exp_r.hnd)
                begin
                    $error("task_handler expected %h actual %h", exp_r.hnd, got.hnd);
                    fail_cnt++;
                end
                if (got.ctx !== exp_r.ctx)
                begin
                    $error("task_context expected %h actual %h", exp_r.ctx, got.ctx);
                    fail_cnt++;
                end
                if (got.pri !== exp_r.pri)
                begin
                    $error("task_priority expected %h actual %h", exp_r.pri, got.pri);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver back-pressure, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Picks a handle: mostly slots in use, sometimes any slot.
    function automatic logic [HDL_W-1:0] pick_handle();
        int unsigned s;
        if ($urandom_range(9) < 8 && free_cnt != 0)
        begin
            for (int k = 0; k < 16; k++)
            begin
                s = $urandom_range(NTASK - 1);
                if (sh_used[s])
                    return s[5:0];
            end
        end
        return HDL_W'($urandom_range(NTASK - 1));
    endfunction

    // Random request mix; priorities cluster so that ties are common.
    task automatic random_request();
        int unsigned sel;
        logic [OP_W-1:0] op;
        logic [15:0] pri;
        logic [15:0] hnd;
        sel = $urandom_range(99);
        if (sel < 35)
            op = OP_ADD;
        else if (sel < 50)
            op = OP_DELETE;
        else if (sel < 60)
            op = OP_CHANGE;
        else if (sel < 66)
            op = OP_START;
        else if (sel < 98)
            op = OP_NEXT;
        else
            op = OP_W'($urandom_range(7, 5));
        pri = ($urandom_range(3) == 0) ? PRI_W'($urandom()) : PRI_W'($urandom_range(7));
        hnd = ($urandom_range(4) == 0) ? '0 : HND_W'($urandom());
        send_request(op, pick_handle(), pri, hnd, $urandom());
    endtask

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        task_rsp_t r;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_START;
        req.handle = '0;
        req.priority_req = '0;
        req.handler_code = '0;
        req.context_tag = '0;
        hold_off = 0;
        fail_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pool_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        rows.push_back('{OP_NEXT, 0, 0, 0, 0, 1, bare_rsp(RS_FINISHED)});
        rows.push_back('{OP_DELETE, 63, 0, 0, 0, 1, bare_rsp(RS_BAD)});
        rows.push_back('{OP_CHANGE, 5, 0, 16'h1, 0, 1, bare_rsp(RS_BAD)});
        r = '{RS_OK, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF};
        rows.push_back('{OP_ADD, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, r});
        r = '{RS_OK, 6'd1, 16'h0001, 32'h0, 16'h0};
        rows.push_back('{OP_ADD, 0, 16'h0, 16'h1, 32'h0, 1, r});
        rows.push_back('{OP_ADD, 0, 16'h5, 16'h0, 32'hA5A5_5A5A, 0, r});
        rows.push_back('{OP_ADD, 0, 16'h5, 16'h77, 32'h1234_5678, 0, r});
        rows.push_back('{OP_START, 0, 0, 0, 0, 1, bare_rsp(RS_OK)});
        rows.push_back('{OP_NEXT, 0, 0, 0, 0, 0, r});
        rows.push_back('{OP_ADD, 0, 16'h0, 16'h9, 32'h1, 0, r});
        rows.push_back('{OP_ADD, 0, 16'h3, 16'h9, 32'h2, 0, r});
        rows.push_back('{OP_NEXT, 0, 0, 0, 0, 0, r});
        rows.push_back('{OP_DELETE, 3, 0, 0, 0, 0, r});
        rows.push_back('{OP_ADD, 0, 16'h4, 16'h8, 32'h3, 0, r});
        rows.push_back('{OP_CHANGE, 2, 0, 16'hBEEF, 0, 0, r});
        rows.push_back('{OP_NEXT, 0, 0, 0, 0, 0, r});
        rows.push_back('{OP_NEXT, 0, 0, 0, 0, 0, r});
        rows.push_back('{OP_NEXT, 0, 0, 0, 0, 0, r});
        rows.push_back('{OP_NEXT, 0, 0, 0, 0, 0, r});
        rows.push_back('{OP_ADD, 0, 16'h2, 16'h2, 32'h4, 0, r});
        rows.push_back('{3'd7, 6'h3F, 0, 0, 0, 1, bare_rsp(RS_OK)});
        rows.push_back('{3'd5, 0, 0, 0, 0, 1, bare_rsp(RS_OK)});
        foreach (rows[i])
        begin
            row = rows[i];
            send_request(row.op, row.hdl, row.pri, row.hnd, row.ctx);
            if (row.chk && pending_rsp[$] !== row.rsp)
            begin
                $error("table row %0d: prediction %h, table %h", i, pending_rsp[$], row.rsp);
                fail_cnt++;
            end
        end
        drain_responses();

        // Fill the pool to full while the receiver holds off.
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            while (free_cnt < NTASK)
                send_request(OP_ADD, '0, PRI_W'($urandom_range(15)), HND_W'($urandom()),
                             $urandom());
        join
        send_request(OP_ADD, 0, 0, 1, 1);
        drain_responses();
        // Empty it again.
        for (int i = 0; i < NTASK; i++)
            send_request(OP_DELETE, HDL_W'(i), 0, 0, 0);
        drain_responses();

        // Random phases with different idle and stall rates.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 48) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 10 : 48) : 0;
            for (int i = 0; i < 280; i++)
                random_request();
        end
        drain_responses();

        repeat (300) @(negedge clk);
        if (fail_cnt == 0 && pending_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
